### hw/rtl/fixed_block_free_list_allocator_defines.svh
// assertion helpers for the block pool allocator
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define FBFL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define FBFL_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define FBFL_ASSERT(lbl, clk, rst_n, prop, msg)
`define FBFL_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

### hw/rtl/fbfl_pkg.sv
package fbfl_pkg;

  localparam int unsigned MaxBlocks = 1024;
  localparam int unsigned AddrWidth = 32;
  localparam int unsigned IdxW      = $clog2(MaxBlocks);
  localparam int unsigned CountW    = $clog2(MaxBlocks + 1);
  localparam int unsigned PaddrW    = 4;
  localparam int unsigned SizeW     = 17;
  localparam logic [3:0]  AlignMax  = 4'd12;

  localparam logic CmdAcquire = 1'b0;
  localparam logic CmdRelease = 1'b1;

  typedef enum logic [1:0] {
    StOk            = 2'd0,
    StExhausted     = 2'd1,
    StNullAddr      = 2'd2,
    StNoOutstanding = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    RegPoolBase    = 2'd0,
    RegElementSize = 2'd1,
    RegAlignLog2   = 2'd2,
    RegBlockCount  = 2'd3
  } reg_e;

  typedef struct packed {
    logic        cmd;
    logic [31:0] release_addr;
  } req_t;

  typedef struct packed {
    logic [31:0] block_addr;
    status_e     status;
    logic [10:0] acquired_count;
    logic [10:0] available_count;
    logic        pool_empty;
  } rsp_t;

  typedef struct packed {
    logic [31:0] pool_base;
    logic [15:0] element_size;
    logic [3:0]  align_log2;
    logic [10:0] block_count;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] base;
  } restart_t;

  typedef struct packed {
    logic                 from_ring;
    logic [AddrWidth-1:0] addr;
    status_e              status;
    logic [CountW-1:0]    acquired_count;
    logic [CountW-1:0]    available_count;
    logic                 pool_empty;
  } dec_t;

  // element size rounded up to the alignment, one unit when the size is zero
  function automatic logic [SizeW-1:0] alloc_size(input logic [15:0] es,
                                                  input logic [3:0] al);
    logic [3:0]       a;
    logic [SizeW-1:0] unit;
    logic [SizeW-1:0] sz;
    a    = (al > AlignMax) ? AlignMax : al;
    unit = SizeW'(1) << a;
    if (es == 16'd0) begin
      sz = unit;
    end else begin
      sz = (SizeW'(es) + unit - SizeW'(1)) & ~(unit - SizeW'(1));
    end
    return sz;
  endfunction

endpackage

### hw/rtl/fbfl_ram.sv
module fbfl_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/fbfl_cfg.sv
module fbfl_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fbfl_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output fbfl_pkg::cfg_t              cfg_o,
  output fbfl_pkg::restart_t          restart_o
);

  fbfl_pkg::cfg_t cfg_q, cfg_d;
  fbfl_pkg::reg_e sel;
  logic           wr;

  assign sel    = fbfl_pkg::reg_e'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      case (sel)
        fbfl_pkg::RegPoolBase:    cfg_d.pool_base    = pwdata;
        fbfl_pkg::RegElementSize: cfg_d.element_size = pwdata[15:0];
        fbfl_pkg::RegAlignLog2:   cfg_d.align_log2   = pwdata[3:0];
        fbfl_pkg::RegBlockCount:  cfg_d.block_count  = pwdata[10:0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pool_base    <= 32'd0;
      cfg_q.element_size <= 16'd16;
      cfg_q.align_log2   <= 4'd3;
      cfg_q.block_count  <= 11'd1024;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (sel)
      fbfl_pkg::RegPoolBase:    prdata = cfg_q.pool_base;
      fbfl_pkg::RegElementSize: prdata = {16'd0, cfg_q.element_size};
      fbfl_pkg::RegAlignLog2:   prdata = {28'd0, cfg_q.align_log2};
      fbfl_pkg::RegBlockCount:  prdata = {21'd0, cfg_q.block_count};
      default:                  prdata = 32'd0;
    endcase
  end

  // any write restarts the pool with the base it leaves behind
  assign cfg_o           = cfg_q;
  assign restart_o.valid = wr;
  assign restart_o.base  = cfg_d.pool_base;

endmodule

### hw/rtl/fbfl_ctrl.sv
module fbfl_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  fbfl_pkg::cfg_t                 cfg_i,
  input  fbfl_pkg::restart_t             restart_i,
  input  logic                           take_i,
  input  fbfl_pkg::req_t                 req_i,
  output fbfl_pkg::dec_t                 dec_o,
  output logic [fbfl_pkg::AddrWidth-1:0] ring_data_o
);

  localparam int unsigned CountW = fbfl_pkg::CountW;
  localparam int unsigned IdxW   = fbfl_pkg::IdxW;
  localparam int unsigned AddrW  = fbfl_pkg::AddrWidth;

  logic [CountW-1:0] fresh_idx_q, fresh_idx_d;
  logic [AddrW-1:0]  fresh_addr_q, fresh_addr_d;
  logic [IdxW-1:0]   head_q, head_d, tail_q, tail_d;
  logic [CountW-1:0] fill_q, fill_d;
  logic [CountW-1:0] outst_q, outst_d;

  logic [CountW-1:0] count, fresh_left, fresh_left_n;
  logic [CountW:0]   avail;
  logic [fbfl_pkg::SizeW-1:0] size;
  logic              pop, push;

  assign count = (32'(cfg_i.block_count) > fbfl_pkg::MaxBlocks) ?
                 CountW'(fbfl_pkg::MaxBlocks) : CountW'(cfg_i.block_count);
  assign fresh_left = (fresh_idx_q < count) ? count - fresh_idx_q : '0;
  assign size = fbfl_pkg::alloc_size(cfg_i.element_size, cfg_i.align_log2);

  always_comb begin
    fresh_idx_d   = fresh_idx_q;
    fresh_addr_d  = fresh_addr_q;
    head_d        = head_q;
    tail_d        = tail_q;
    fill_d        = fill_q;
    outst_d       = outst_q;
    pop           = 1'b0;
    push          = 1'b0;
    dec_o.from_ring = 1'b0;
    dec_o.addr      = '0;
    dec_o.status    = fbfl_pkg::StOk;
    if (req_i.cmd == fbfl_pkg::CmdAcquire) begin
      if (fresh_left != '0) begin
        dec_o.addr   = fresh_addr_q;
        fresh_addr_d = fresh_addr_q + AddrW'(size);
        fresh_idx_d  = fresh_idx_q + 1'b1;
        outst_d      = outst_q + 1'b1;
      end else if (fill_q != '0) begin
        pop             = 1'b1;
        dec_o.from_ring = 1'b1;
        head_d = (head_q == IdxW'(fbfl_pkg::MaxBlocks - 1)) ? '0 : head_q + 1'b1;
        fill_d  = fill_q - 1'b1;
        outst_d = outst_q + 1'b1;
      end else begin
        dec_o.status = fbfl_pkg::StExhausted;
      end
    end else begin
      if (req_i.release_addr == 32'd0) begin
        dec_o.status = fbfl_pkg::StNullAddr;
      end else if (outst_q == '0) begin
        dec_o.status = fbfl_pkg::StNoOutstanding;
      end else begin
        push    = 1'b1;
        tail_d  = (tail_q == IdxW'(fbfl_pkg::MaxBlocks - 1)) ? '0 : tail_q + 1'b1;
        fill_d  = fill_q + 1'b1;
        outst_d = outst_q - 1'b1;
      end
    end
    fresh_left_n          = (fresh_idx_d < count) ? count - fresh_idx_d : '0;
    avail                 = {1'b0, fresh_left_n} + {1'b0, fill_d};
    dec_o.acquired_count  = outst_d;
    dec_o.available_count = avail[CountW-1:0];
    dec_o.pool_empty      = (avail == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_idx_q  <= '0;
      fresh_addr_q <= '0;
      head_q       <= '0;
      tail_q       <= '0;
      fill_q       <= '0;
      outst_q      <= '0;
    end else if (restart_i.valid) begin
      fresh_idx_q  <= '0;
      fresh_addr_q <= AddrW'(restart_i.base);
      head_q       <= '0;
      tail_q       <= '0;
      fill_q       <= '0;
      outst_q      <= '0;
    end else if (take_i) begin
      fresh_idx_q  <= fresh_idx_d;
      fresh_addr_q <= fresh_addr_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      fill_q       <= fill_d;
      outst_q      <= outst_d;
    end
  end

  fbfl_ram #(
    .Width(AddrW),
    .Depth(fbfl_pkg::MaxBlocks)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (take_i && push),
    .waddr_i(tail_q),
    .wdata_i(AddrW'(req_i.release_addr)),
    .re_i   (take_i && pop),
    .raddr_i(head_q),
    .rdata_o(ring_data_o)
  );

endmodule

### hw/rtl/fixed_block_free_list_allocator.sv
// channel   direction  payload          transfer when
// in        input      fbfl_pkg::req_t  in_valid_i && in_ready_o
// out       output     fbfl_pkg::rsp_t  out_valid_o && out_ready_i
// apb cfg   input      32-bit register  psel && penable && pwrite && pready
//
// one request per cycle while the output is not stalled; a result passes the request stage, then the result register
// the pool state is updated at transfer, the ring ram read data lands in the cycle after it
// reset and every register write restart the pool at once, the ring is not cleared
// a stalled output holds the result register, the stage behind holds the ram data

`include "fixed_block_free_list_allocator_defines.svh"

module fixed_block_free_list_allocator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  fbfl_pkg::req_t              in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output fbfl_pkg::rsp_t              out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fbfl_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  fbfl_pkg::cfg_t     cfg;
  fbfl_pkg::restart_t restart;
  fbfl_pkg::dec_t     dec, a_q;
  fbfl_pkg::rsp_t     out_q, out_d;
  logic [fbfl_pkg::AddrWidth-1:0] ring_data;
  logic a_valid_q, out_valid_q;
  logic take, b_load;

  assign b_load     = !out_valid_q || out_ready_i;
  assign in_ready_o = !a_valid_q || b_load;
  assign take       = in_valid_i && in_ready_o;

  fbfl_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg_o    (cfg),
    .restart_o(restart)
  );

  fbfl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .restart_i  (restart),
    .take_i     (take),
    .req_i      (in_data_i),
    .dec_o      (dec),
    .ring_data_o(ring_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      a_valid_q <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      a_q <= dec;
    end
  end

  always_comb begin
    out_d.block_addr      = 32'(a_q.from_ring ? ring_data : a_q.addr);
    out_d.status          = a_q.status;
    out_d.acquired_count  = 11'(a_q.acquired_count);
    out_d.available_count = 11'(a_q.available_count);
    out_d.pool_empty      = a_q.pool_empty;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (b_load) begin
      out_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_load && a_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `FBFL_ASSERT(a_hold_a, clk_i, rst_ni, a_valid_q && !b_load |=> a_valid_q && $stable(a_q), "stalled request stage changed")
  `FBFL_ASSERT(exhausted_empty_a, clk_i, rst_ni, out_valid_o && out_data_o.status == fbfl_pkg::StExhausted |-> out_data_o.pool_empty && out_data_o.block_addr == 32'd0, "exhausted result with free blocks")
  `FBFL_ASSERT(count_bound_a, clk_i, rst_ni, out_valid_o |-> (12'(out_data_o.acquired_count) + 12'(out_data_o.available_count)) <= 12'(fbfl_pkg::MaxBlocks), "block counts exceed pool")
  `FBFL_ASSERT_NEVER(null_addr_a, clk_i, rst_ni, out_valid_o && out_data_o.status == fbfl_pkg::StNullAddr && out_data_o.block_addr != 32'd0, "address on null release")

endmodule
